@@ rtl/core/pdf_pkg.sv @@
// Package for the pattern deletion filter: widths, register indexes and the
// result record shared by the interfaces and the RTL modules.
// Depends on nothing.
package pdf_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LEN_W           = 4;
  localparam int unsigned PAT_BYTES       = 8;
  localparam int unsigned PAT_W           = BYTE_W * PAT_BYTES;
  localparam int unsigned PAT_IDX_W       = $clog2(PAT_BYTES);
  localparam int unsigned PATTERN_MAX_DEF = 8;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              out_last;
  } result_t;

endpackage

@@ rtl/core/pdf_if.sv @@
// Handshake interfaces of the pattern deletion filter: text input, filtered
// result output and configuration writes.
// Depends on pdf_pkg.
interface pdf_text_if;
  import pdf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface pdf_result_if;
  import pdf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              has_byte;
  logic              out_last;
  modport source (output valid, out_byte, has_byte, out_last, input ready);
  modport sink (input valid, out_byte, has_byte, out_last, output ready);
endinterface

interface pdf_cfg_if;
  import pdf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PAT_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/pdf_cell.sv @@
// One window cell: holds one byte, passes it to the next cell on a shift,
// and folds its compare against the pattern into the match chain.
// Depends on pdf_pkg.
module pdf_cell (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [pdf_pkg::BYTE_W-1:0] d,
  input  logic [pdf_pkg::BYTE_W-1:0] pat_byte,
  input  logic                      active,
  input  logic                      match_in,
  output logic [pdf_pkg::BYTE_W-1:0] q,
  output logic                      match_out
);
  import pdf_pkg::*;

  // The compare looks at the byte this cell holds after the shift.
  assign match_out = match_in & ((d == pat_byte) | ~active);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= d;
    end
  end

endmodule

@@ rtl/core/pdf_out_buf.sv @@
// Two-entry result queue between the window logic and the output port, so
// that a waiting result does not stop the next byte from being taken.
// Depends on pdf_pkg.
module pdf_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pdf_pkg::result_t push_data,
  output logic             full,
  input  logic             pop_ready,
  output logic             out_valid,
  output pdf_pkg::result_t out_data
);
  import pdf_pkg::*;

  logic [1:0] count;
  result_t    head;
  result_t    tail;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid & pop_ready;
  assign out_data  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          head <= push_data;
        end else begin
          tail <= push_data;
        end
      end
      2'b01: begin
        head <= tail;
      end
      2'b11: begin
        if (count == 2'd1) begin
          head <= push_data;
        end else begin
          head <= tail;
          tail <= push_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/pattern_deletion_filter_core.sv @@
// Pattern deletion filter top level: configuration registers, the chain of
// window cells, step control and the result queue.
// Depends on pdf_pkg, pdf_if, pdf_cell and pdf_out_buf.
//
//   port    | dir | moves
//   --------+-----+---------------------------------------------------
//   cfg     | in  | register write request: index, data
//   text    | in  | one string byte per request: in_byte, in_last
//   result  | out | one result per request: out_byte, has_byte, out_last
//
// A byte is taken every cycle as long as it releases at most one result
// and the result queue is not full. A byte that releases R > 1 results
// (string end, or a lowered length) holds the input off while the window
// drains one byte per cycle from the cell chain, pausing while the queue
// is full. The first result of a byte enters the queue as the byte is
// taken. Reset clears the registers, the fill count, the drain counter and
// the result queue, and holds both inputs off; window bytes are not reset.
// The two-entry result queue lets input continue while one result waits.
module pattern_deletion_filter_core #(
  parameter int unsigned PATTERN_MAX = pdf_pkg::PATTERN_MAX_DEF
) (
  input logic           clk,
  input logic           rst,
  pdf_cfg_if.sink       cfg,
  pdf_text_if.sink      text,
  pdf_result_if.source  result
);
  import pdf_pkg::*;

  localparam int unsigned CNT_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // Configuration registers.
  logic [LEN_W-1:0]  len_reg;
  logic [PAT_W-1:0]  pat_reg;
  logic [BYTE_W-1:0] pat_arr [PAT_BYTES];

  // Window state.
  logic [CNT_W-1:0]  fill;
  logic [BYTE_W-1:0] cell_d [PATTERN_MAX];
  logic [BYTE_W-1:0] cell_q [PATTERN_MAX];
  logic [BYTE_W-1:0] pat_sel [PATTERN_MAX];
  logic              active [PATTERN_MAX];
  logic              match_chain [PATTERN_MAX + 1];

  // Drain of multi-result steps.
  logic [CNT_W-1:0]  drain_cnt;
  logic [IDX_W-1:0]  drain_ptr;
  logic              drain_last;

  logic [LEN_W-1:0]  len_act;
  logic [CNT_W-1:0]  len_c;
  logic [CNT_W-1:0]  nf;
  logic [CNT_W-1:0]  emit_base;
  logic [CNT_W-1:0]  keep;
  logic [CNT_W-1:0]  emit_cnt;
  logic [CNT_W-1:0]  keep_final;
  logic              accept;
  logic              full;
  logic              push;
  result_t           push_res;
  result_t           head_res;

  // Configuration port.
  assign cfg.ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= '0;
      pat_reg <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PATTERN_LENGTH: len_reg <= cfg.data[LEN_W-1:0];
        REG_PATTERN_BYTES:  pat_reg <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  assign len_act = (len_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_reg;
  assign len_c   = CNT_W'(len_act);

  for (genvar b = 0; b < PAT_BYTES; b++) begin : g_pat
    assign pat_arr[b] = pat_reg[b*BYTE_W +: BYTE_W];
  end

  // Newest byte sits in cell 0, so cell j meets pattern byte len - 1 - j.
  assign match_chain[0] = 1'b1;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [LEN_W-1:0] sel;

    assign sel        = len_act - LEN_W'(j) - LEN_W'(1);
    assign pat_sel[j] = pat_arr[sel[PAT_IDX_W-1:0]];
    assign active[j]  = (CNT_W'(j) < len_c);

    if (j == 0) begin : g_head
      assign cell_d[j] = text.in_byte;
    end else begin : g_body
      assign cell_d[j] = cell_q[j-1];
    end

    pdf_cell u_cell (
      .clk       (clk),
      .shift_en  (accept),
      .d         (cell_d[j]),
      .pat_byte  (pat_sel[j]),
      .active    (active[j]),
      .match_in  (match_chain[j]),
      .q         (cell_q[j]),
      .match_out (match_chain[j+1])
    );
  end

  // Step arithmetic for the byte on the input.
  assign nf = fill + CNT_W'(1);

  always_comb begin
    emit_base = '0;
    keep      = nf;
    priority if (len_c == '0) begin
      emit_base = nf;
      keep      = '0;
    end else if (nf >= len_c) begin
      if (match_chain[PATTERN_MAX]) begin
        emit_base = nf - len_c;
        keep      = '0;
      end else begin
        emit_base = nf - len_c + CNT_W'(1);
        keep      = len_c - CNT_W'(1);
      end
    end else begin
      emit_base = '0;
      keep      = nf;
    end
  end

  assign emit_cnt   = text.in_last ? (emit_base + keep) : emit_base;
  assign keep_final = text.in_last ? '0 : keep;

  assign text.ready = (drain_cnt == '0) & ~full & ~rst;
  assign accept     = text.valid & text.ready;

  // The oldest byte released by a step is at cell fill after the shift.
  always_comb begin
    push_res = '0;
    push     = 1'b0;
    if (drain_cnt != '0) begin
      push              = ~full;
      push_res.out_byte = cell_q[drain_ptr];
      push_res.has_byte = 1'b1;
      push_res.out_last = drain_last & (drain_cnt == CNT_W'(1));
    end else if (accept) begin
      push              = (emit_cnt != '0) | text.in_last;
      push_res.has_byte = (emit_cnt != '0);
      push_res.out_byte = push_res.has_byte ? cell_d[fill[IDX_W-1:0]] : '0;
      push_res.out_last = text.in_last & (emit_cnt <= CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      drain_cnt <= '0;
    end else if (drain_cnt != '0) begin
      if (~full) begin
        drain_cnt <= drain_cnt - CNT_W'(1);
      end
    end else if (accept) begin
      fill <= keep_final;
      if (emit_cnt > CNT_W'(1)) begin
        drain_cnt <= emit_cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain_cnt != '0) begin
      if (~full) begin
        drain_ptr <= drain_ptr - IDX_W'(1);
      end
    end else if (accept) begin
      drain_ptr  <= IDX_W'(fill - CNT_W'(1));
      drain_last <= text.in_last;
    end
  end

  pdf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_res),
    .full      (full),
    .pop_ready (result.ready),
    .out_valid (result.valid),
    .out_data  (head_res)
  );

  assign result.out_byte = head_res.out_byte;
  assign result.has_byte = head_res.has_byte;
  assign result.out_last = head_res.out_last;

  // The window never fills up to PATTERN_MAX bytes between steps.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill < CNT_W'(PATTERN_MAX))
    else $error("window fill reached the pattern limit");

  // A result is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ~full)
    else $error("result pushed into a full queue");

  // The end of a string leaves an empty window.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && text.in_last |=> fill == '0)
    else $error("window not empty after the last byte");

  // An end-only marker always closes a string.
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    push && !push_res.has_byte |-> push_res.out_last)
    else $error("empty result without the last flag");

  // A drain runs down by one on every cycle the queue has room.
  a_drain_step: assert property (@(posedge clk) disable iff (rst)
    drain_cnt != '0 && !full |=> drain_cnt == $past(drain_cnt) - CNT_W'(1))
    else $error("drain counter did not advance");

endmodule
